### hdl/sta_pkg.sv
// Shared types, constants and codes of the sparse term accumulator.
package sta_pkg;

  localparam int MAX_TERMS    = 16;
  localparam int RESULT_SLOTS = 16;
  localparam int CAPACITY     = (MAX_TERMS < RESULT_SLOTS) ? MAX_TERMS : RESULT_SLOTS;
  localparam int IDX_W        = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int USED_W       = $clog2(CAPACITY + 1);
  localparam int RAM_DEPTH    = 1 << IDX_W;

  localparam int ACT_W   = 2;
  localparam int VAR_W   = 8;
  localparam int EXP_W   = 8;
  localparam int COEF_W  = 32;
  localparam int SLOT_W  = 4;

  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_EMIT  = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_INSERT,
    ST_EMIT
  } state_t;

  // one table entry as held in the term memory
  typedef struct packed {
    logic [VAR_W-1:0]         variable;
    logic [EXP_W-1:0]         exponent;
    logic signed [COEF_W-1:0] coefficient;
  } entry_t;

  // one input word
  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [VAR_W-1:0]         variable;
    logic [EXP_W-1:0]         exponent;
    logic signed [COEF_W-1:0] coefficient;
  } item_t;

  // one result word
  typedef struct packed {
    logic [SLOT_W-1:0]        slot;
    logic [VAR_W-1:0]         term_variable;
    logic [EXP_W-1:0]         term_exponent;
    logic signed [COEF_W-1:0] term_coefficient;
    logic                     merged;
    logic                     table_full;
    logic                     saturated;
    logic                     empty_res;
    logic                     last;
  } res_t;

endpackage

### hdl/sparse_term_accumulator_top.sv
// Top level of the sparse term accumulator: term memory, sequencer and ports.
// Clear empties the table and produces no word. Add searches the slots in use in order
//   and merges into a matching slot, else registers a new term or a dropped one (table full).
// Emit: one word per slot in use (one empty word if none), one word per cycle while out_ready.
// Flow: one word in flight, the next accepted once the last result of the previous one is
//   registered; out_ready low holds the result and stalls the sequencer.
// Reset (rst_n low, synchronous): fill count 0, output invalid; memory not cleared.
module sparse_term_accumulator_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [sta_pkg::ACT_W-1:0]           in_action,
  input  logic [sta_pkg::VAR_W-1:0]           in_variable,
  input  logic [sta_pkg::EXP_W-1:0]           in_exponent,
  input  logic signed [sta_pkg::COEF_W-1:0]   in_coefficient,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [sta_pkg::SLOT_W-1:0]          out_slot,
  output logic [sta_pkg::VAR_W-1:0]           out_term_variable,
  output logic [sta_pkg::EXP_W-1:0]           out_term_exponent,
  output logic signed [sta_pkg::COEF_W-1:0]   out_term_coefficient,
  output logic                                out_merged,
  output logic                                out_table_full,
  output logic                                out_saturated,
  output logic                                out_empty_res,
  output logic                                out_last
);

  sta_pkg::item_t              item;
  sta_pkg::res_t               res;
  logic                        wr_en;
  logic [sta_pkg::IDX_W-1:0]   wr_addr;
  logic [sta_pkg::IDX_W-1:0]   rd_addr;
  sta_pkg::entry_t             wr_data;
  sta_pkg::entry_t             rd_data;

  assign item.action      = in_action;
  assign item.variable    = in_variable;
  assign item.exponent    = in_exponent;
  assign item.coefficient = in_coefficient;

  // term memory: variable, exponent and coefficient of each slot in one word
  sta_ram #(
    .WIDTH ($bits(sta_pkg::entry_t)),
    .DEPTH (sta_pkg::RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer with the output register; accepts a word only when idle
  sta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .item      (item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  assign out_slot             = res.slot;
  assign out_term_variable    = res.term_variable;
  assign out_term_exponent    = res.term_exponent;
  assign out_term_coefficient = res.term_coefficient;
  assign out_merged           = res.merged;
  assign out_table_full       = res.table_full;
  assign out_saturated        = res.saturated;
  assign out_empty_res        = res.empty_res;
  assign out_last             = res.last;

  // a dropped term never reports a merge or a clamp
  a_full_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> !out_merged && !out_saturated)
    else $error("table_full word also flags merge or saturation");

  // clamping only happens on a merge
  a_sat_merge: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_merged)
    else $error("saturated word without merge");

  // empty emit word is all zero and closes the sequence
  a_empty_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_res |->
      out_last && (out_slot == '0) && (out_term_coefficient == '0) && !out_merged)
    else $error("malformed empty word");

  // clear leaves the sequencer idle, ready again in the next cycle, and produces no word
  a_clear_quick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_action == sta_pkg::ACT_CLEAR) |=> in_ready)
    else $error("clear did not return to idle");

endmodule

### hdl/sta_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### hdl/sta_ctrl.sv
// Sequencer: clear, key search, saturating merge, insert and emit over the term memory.
module sta_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  sta_pkg::item_t              item,
  output logic                        out_valid,
  input  logic                        out_ready,
  output sta_pkg::res_t               res,
  output logic                        wr_en,
  output logic [sta_pkg::IDX_W-1:0]   wr_addr,
  output sta_pkg::entry_t             wr_data,
  output logic [sta_pkg::IDX_W-1:0]   rd_addr,
  input  sta_pkg::entry_t             rd_data
);

  sta_pkg::state_t                  state_r, state_nxt;
  logic [sta_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  logic [sta_pkg::USED_W-1:0]       used_r, used_nxt;
  sta_pkg::entry_t                  key_r, key_nxt;
  logic                             out_valid_r, out_valid_nxt;
  sta_pkg::res_t                    res_r, res_nxt;

  logic                             out_free;
  logic                             match;
  logic                             at_end;
  logic signed [sta_pkg::COEF_W:0]  sum_w;
  logic                             sat_w;
  logic signed [sta_pkg::COEF_W-1:0] coef_w;

  assign out_free = !out_valid_r || out_ready;
  assign match    = (rd_data.variable == key_r.variable) &&
                    (rd_data.exponent == key_r.exponent);
  assign at_end   = (sta_pkg::USED_W'(idx_r) + sta_pkg::USED_W'(1)) == used_r;
  assign sum_w    = {rd_data.coefficient[sta_pkg::COEF_W-1], rd_data.coefficient} +
                    {key_r.coefficient[sta_pkg::COEF_W-1], key_r.coefficient};
  assign sat_w    = sum_w[sta_pkg::COEF_W] ^ sum_w[sta_pkg::COEF_W-1];
  assign coef_w   = !sat_w ? sum_w[sta_pkg::COEF_W-1:0] :
                    (sum_w[sta_pkg::COEF_W] ? sta_pkg::COEF_MIN : sta_pkg::COEF_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sta_pkg::ST_IDLE;
      idx_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    used_nxt      = used_r;
    key_nxt       = key_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    wr_en         = 1'b0;
    wr_addr       = idx_r;
    wr_data       = key_r;
    in_ready      = (state_r == sta_pkg::ST_IDLE);

    case (state_r)
      sta_pkg::ST_IDLE: begin
        if (in_valid) begin
          key_nxt.variable    = item.variable;
          key_nxt.exponent    = (item.variable == '0) ? '0 : item.exponent;
          key_nxt.coefficient = item.coefficient;
          idx_nxt             = '0;
          case (sta_pkg::action_t'(item.action))
            sta_pkg::ACT_CLEAR: used_nxt = '0;
            sta_pkg::ACT_ADD: begin
              state_nxt = (used_r == '0) ? sta_pkg::ST_INSERT : sta_pkg::ST_SEARCH;
            end
            sta_pkg::ACT_EMIT:  state_nxt = sta_pkg::ST_EMIT;
            default: ;
          endcase
        end
      end

      // rd_data holds the entry at idx_r
      sta_pkg::ST_SEARCH: begin
        if (match) begin
          if (out_free) begin
            wr_en                       = 1'b1;
            wr_data                     = rd_data;
            wr_data.coefficient         = coef_w;
            out_valid_nxt               = 1'b1;
            res_nxt                     = '0;
            res_nxt.slot                = sta_pkg::SLOT_W'(idx_r);
            res_nxt.term_variable       = key_r.variable;
            res_nxt.term_exponent       = key_r.exponent;
            res_nxt.term_coefficient    = coef_w;
            res_nxt.merged              = 1'b1;
            res_nxt.saturated           = sat_w;
            res_nxt.last                = 1'b1;
            state_nxt                   = sta_pkg::ST_IDLE;
          end
        end else if (at_end) begin
          state_nxt = sta_pkg::ST_INSERT;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      sta_pkg::ST_INSERT: begin
        if (out_free) begin
          out_valid_nxt            = 1'b1;
          res_nxt                  = '0;
          res_nxt.term_variable    = key_r.variable;
          res_nxt.term_exponent    = key_r.exponent;
          res_nxt.term_coefficient = key_r.coefficient;
          res_nxt.last             = 1'b1;
          if (used_r == sta_pkg::USED_W'(sta_pkg::CAPACITY)) begin
            res_nxt.table_full = 1'b1;
          end else begin
            wr_en        = 1'b1;
            wr_addr      = used_r[sta_pkg::IDX_W-1:0];
            res_nxt.slot = sta_pkg::SLOT_W'(used_r);
            used_nxt     = used_r + 1'b1;
          end
          state_nxt = sta_pkg::ST_IDLE;
        end
      end

      sta_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          res_nxt       = '0;
          if (used_r == '0) begin
            res_nxt.empty_res = 1'b1;
            res_nxt.last      = 1'b1;
            state_nxt         = sta_pkg::ST_IDLE;
          end else begin
            res_nxt.slot             = sta_pkg::SLOT_W'(idx_r);
            res_nxt.term_variable    = rd_data.variable;
            res_nxt.term_exponent    = rd_data.exponent;
            res_nxt.term_coefficient = rd_data.coefficient;
            res_nxt.last             = at_end;
            if (at_end) begin
              state_nxt = sta_pkg::ST_IDLE;
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
        end
      end

      default: state_nxt = sta_pkg::ST_IDLE;
    endcase
  end

  // read one ahead so that rd_data matches idx_r in the search and emit states
  assign rd_addr   = idx_nxt;
  assign out_valid = out_valid_r;
  assign res       = res_r;

endmodule
